@@ sv/cscs_pkg.sv @@
// Shared types, widths and helpers for the Catmull-Rom coefficient stream.
// No dependencies; imported by cscs_coef and cubic_spline_coeff_stream.
package cscs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int INDEX_BITS  = 16;
  localparam int COEF_BITS   = 32;

  // Coefficient math width: at least 18x the sample range, and wide enough for the clamp limits.
  localparam int MATH_BITS = SAMPLE_BITS + 6;
  localparam int WIDE_BITS = (MATH_BITS > COEF_BITS + 1) ? MATH_BITS : COEF_BITS + 1;

  localparam int SEEN_BITS = INDEX_BITS + 1;

  localparam int TDATA_IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RESULT_BITS    = 4 * COEF_BITS + INDEX_BITS;
  localparam int TDATA_OUT_BITS = ((RESULT_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic        [INDEX_BITS-1:0]  index_t;
  typedef logic        [SEEN_BITS-1:0]   seen_t;

  typedef struct packed {
    coef_t c3;
    coef_t c2;
    coef_t c1;
    coef_t c0;
  } coefs_t;

  typedef struct packed {
    logic   last;
    index_t index;
    coefs_t coefs;
  } result_t;

  localparam wide_t COEF_MAX = wide_t'(64'sh0000_0000_7FFF_FFFF);
  localparam wide_t COEF_MIN = wide_t'(-64'sh0000_0000_8000_0000);

  function automatic coef_t sat_coef(wide_t v);
    coef_t r;
    if (v > COEF_MAX) begin
      r = COEF_MAX[COEF_BITS-1:0];
    end else if (v < COEF_MIN) begin
      r = COEF_MIN[COEF_BITS-1:0];
    end else begin
      r = v[COEF_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/cscs_coef.sv @@
// Combinational Catmull-Rom coefficients (each times two) from four control points.
// Depends on cscs_pkg.
module cscs_coef (
  input  cscs_pkg::wide_t  p0_i,
  input  cscs_pkg::wide_t  p1_i,
  input  cscs_pkg::wide_t  p2_i,
  input  cscs_pkg::wide_t  p3_i,
  output cscs_pkg::coefs_t coefs_o
);
  import cscs_pkg::*;

  wide_t c0, c1, c2, c3;

  // shifts and adds only: 5*p1 = 4*p1 + p1, 3*x = 2*x + x
  assign c0 = p1_i <<< 1;
  assign c1 = p2_i - p0_i;
  assign c2 = (p0_i <<< 1) - ((p1_i <<< 2) + p1_i) + (p2_i <<< 2) - p3_i;
  assign c3 = ((p1_i <<< 1) + p1_i) - p0_i - ((p2_i <<< 1) + p2_i) + p3_i;

  assign coefs_o.c0 = sat_coef(c0);
  assign coefs_o.c1 = sat_coef(c1);
  assign coefs_o.c2 = sat_coef(c2);
  assign coefs_o.c3 = sat_coef(c3);

endmodule

@@ sv/cubic_spline_coeff_stream.sv @@
// Catmull-Rom cubic coefficient stream: samples in, per-interval coefficients out.
// Results are registered in the result queue before they reach the master side.
// Throughput: one sample per cycle while two queue entries are free; a final sample
// can give two results; a four-entry queue drains them at one transfer per cycle.
// Reset (rst_ni low, async): sample window, sample count and result queue are cleared.
// Depends on cscs_pkg and cscs_coef.
module cubic_spline_coeff_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [cscs_pkg::TDATA_IN_BITS-1:0]  s_axis_tdata_i,  // [0] sample
  input  logic                                s_axis_tlast_i,  // last_sample
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // coef0, coef1, coef2, coef3, interval_index (lowest bits first)
  output logic [cscs_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata_o,
  output logic                                m_axis_tlast_o   // last_interval
);
  import cscs_pkg::*;

  // ---------------- state ----------------
  sample_t w0_q, w1_q, w2_q;
  seen_t   seen_q, seen_d;

  result_t              fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]  count_q, count_d;

  logic    in_fire, out_fire;
  sample_t s;
  logic    k_ge1, k_ge2, k_ge3;
  logic    emit_mid, emit_end;
  logic [1:0] push_n;

  assign s        = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign k_ge1 = (seen_q != '0);
  assign k_ge2 = (seen_q > seen_t'(1));
  assign k_ge3 = (seen_q > seen_t'(2));

  assign emit_mid = k_ge2;
  assign emit_end = s_axis_tlast_i && k_ge1;
  assign push_n   = in_fire ? (2'(emit_mid) + 2'(emit_end)) : 2'd0;

  // ---------------- coefficient datapath ----------------
  wide_t ws, ww0, ww1, ww2;
  wide_t m_p0, e_p0, e_p3;
  coefs_t mid_coefs, end_coefs;
  result_t mid_res, end_res, slot0, slot1;
  index_t  k_idx;

  assign ws  = wide_t'(s);
  assign ww0 = wide_t'(w0_q);
  assign ww1 = wide_t'(w1_q);
  assign ww2 = wide_t'(w2_q);

  // missing left and right neighbors are extrapolated linearly
  assign m_p0 = k_ge3 ? ww0 : ((ww1 <<< 1) - ww2);
  assign e_p0 = k_ge2 ? ww1 : ((ww2 <<< 1) - ws);
  assign e_p3 = (ws <<< 1) - ww2;

  cscs_coef u_mid (
    .p0_i   (m_p0),
    .p1_i   (ww1),
    .p2_i   (ww2),
    .p3_i   (ws),
    .coefs_o(mid_coefs)
  );

  cscs_coef u_end (
    .p0_i   (e_p0),
    .p1_i   (ww2),
    .p2_i   (ws),
    .p3_i   (e_p3),
    .coefs_o(end_coefs)
  );

  assign k_idx = seen_q[INDEX_BITS-1:0];

  assign mid_res.coefs = mid_coefs;
  assign mid_res.index = k_idx - index_t'(2);
  assign mid_res.last  = 1'b0;
  assign end_res.coefs = end_coefs;
  assign end_res.index = k_idx - index_t'(1);
  assign end_res.last  = 1'b1;

  assign slot0 = emit_mid ? mid_res : end_res;
  assign slot1 = end_res;

  // ---------------- sample window and count ----------------
  always_comb begin
    if (s_axis_tlast_i) begin
      seen_d = '0;
    end else if (seen_q == {SEEN_BITS{1'b1}}) begin
      // long series: wrap back to 2^INDEX_BITS so the count stays at or above three
      seen_d = seen_t'(1) << INDEX_BITS;
    end else begin
      seen_d = seen_q + seen_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q   <= '0;
      w1_q   <= '0;
      w2_q   <= '0;
      seen_q <= '0;
    end else if (in_fire) begin
      seen_q <= seen_d;
      if (s_axis_tlast_i) begin
        w0_q <= '0;
        w1_q <= '0;
        w2_q <= '0;
      end else begin
        w0_q <= w1_q;
        w1_q <= w2_q;
        w2_q <= s;
      end
    end
  end

  // ---------------- result queue ----------------
  // ready only with room for two results, the worst case of one sample
  assign s_axis_tready_o = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign count_d = count_q + CNT_BITS'(push_n) - CNT_BITS'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_BITS'(out_fire);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_BITS'(1)] <= slot1;
    end
  end

  result_t head;
  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = TDATA_OUT_BITS'({head.index, head.coefs.c3, head.coefs.c2,
                                            head.coefs.c1, head.coefs.c0});
  assign m_axis_tlast_o  = head.last;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_BITS'(FIFO_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_two_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (s_axis_tlast_i && k_ge2))
    else $error("two results from a sample that does not end the series");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast_i) |=> (seen_q == '0 && w2_q == '0))
    else $error("series state not restarted after final sample");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !s_axis_tlast_i) |=> (seen_q != '0))
    else $error("sample count lost after a transfer");

endmodule
